// ===== src/bor_pkg.sv =====
package bor_pkg;

  // Fixed field widths
  localparam int unsigned COUNT_W  = 64;
  localparam int unsigned DATA_W   = 64;
  localparam int unsigned RID_W    = 3;

  // Parameter defaults
  localparam int unsigned RING_DEPTH_DEF  = 256;
  localparam int unsigned NUM_READERS_DEF = 8;
  localparam int unsigned ENTRY_BITS_DEF  = 64;

  // Result status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  typedef enum logic [1:0] {
    CMD_PUBLISH = 2'd0,
    CMD_READ    = 2'd1,
    CMD_OPEN    = 2'd2,
    CMD_STATS   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FETCH
  } state_e;

endpackage

// ===== src/bor_ring_mem.sv =====
module bor_ring_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 64,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/bor_cursor_mem.sv =====
module bor_cursor_mem #(
  parameter int unsigned NUM_READERS = 8,
  parameter int unsigned WIDTH       = 72,
  localparam int unsigned IW         = (NUM_READERS > 1) ? $clog2(NUM_READERS) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             re_i,
  input  logic [IW-1:0]    ridx_i,
  output logic [WIDTH-1:0] rdata_o,
  input  logic             we_i,
  input  logic [IW-1:0]    widx_i,
  input  logic [WIDTH-1:0] wdata_i
);

  logic [WIDTH-1:0]       mem [NUM_READERS];
  logic [NUM_READERS-1:0] vld_q;
  logic [WIDTH-1:0]       rdata_q;
  logic                   rvld_q;

  // Mark written entries; an unwritten cursor reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[widx_i] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= vld_q[ridx_i];
      end
    end
  end

  // Storage with registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[widx_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[ridx_i];
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

// ===== src/broadcast_overwrite_ring_unit.sv =====
// Sequence: a result strobes from the result registers once the EXEC state ends; a successful
// read also passes through the FETCH state for the ring memory fetch.
// Flow: busy holds off a new transaction until the current one has left EXEC, or FETCH for a
// read that returns an entry; the cursor memory read precedes the ring memory read.
// Reset: head, totals and all reader cursors clear at once; ring contents are undefined
// until written. Results cannot be stalled by the receiver.
module broadcast_overwrite_ring_unit
  import bor_pkg::*;
#(
  parameter int unsigned RING_DEPTH  = RING_DEPTH_DEF,
  parameter int unsigned NUM_READERS = NUM_READERS_DEF,
  parameter int unsigned ENTRY_BITS  = ENTRY_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd_i,
  input  logic [RID_W-1:0]   reader_id_i,
  input  logic [DATA_W-1:0]  payload_i,
  output logic               result_valid_o,
  output logic               status_o,
  output logic [DATA_W-1:0]  read_data_o,
  output logic               overrun_o,
  output logic [COUNT_W-1:0] published_count_o,
  output logic [COUNT_W-1:0] dropped_count_o
);

  localparam int unsigned AW    = $clog2(RING_DEPTH);
  localparam int unsigned IW    = (NUM_READERS > 1) ? $clog2(NUM_READERS) : 1;
  localparam int unsigned CUR_W = COUNT_W + AW;

  state_e state_q, state_d;
  logic   accept;

  // Latched transaction
  cmd_e                  cmd_q;
  logic [RID_W-1:0]      rid_q;
  logic [ENTRY_BITS-1:0] payload_q;

  // Ring bookkeeping
  logic [COUNT_W-1:0] head_q, head_d;
  logic [COUNT_W-1:0] head_sub_q, head_sub_d;
  logic [AW-1:0]      head_slot_q, head_slot_d;
  logic [COUNT_W-1:0] pub_q, pub_d;
  logic [COUNT_W-1:0] drop_q, drop_d;

  // Read in flight
  logic [COUNT_W-1:0] eff_q, eff_d;
  logic [AW-1:0]      eff_slot_q, eff_slot_d;
  logic               over_q, over_d;

  // Result registers
  logic               res_valid_q, res_valid_d;
  logic               status_q, status_d;
  logic [DATA_W-1:0]  rdata_q, rdata_d;
  logic               overrun_q, overrun_d;
  logic [COUNT_W-1:0] pubc_q, pubc_d;
  logic [COUNT_W-1:0] dropc_q, dropc_d;

  // Memory ports
  logic                  ring_we, ring_re;
  logic [ENTRY_BITS-1:0] ring_rdata;
  logic                  cur_we;
  logic [CUR_W-1:0]      cur_rdata, cur_wdata;

  // Datapath terms
  logic               rid_ok;
  logic [COUNT_W-1:0] cur_cnt;
  logic [AW-1:0]      cur_slot;
  logic [COUNT_W-1:0] oldest;
  logic               head_above;
  logic               empty;
  logic               lagging;
  logic [COUNT_W-1:0] eff_inc;
  logic [AW-1:0]      eff_slot_inc;

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);

  bor_ring_mem #(
    .DEPTH (RING_DEPTH),
    .WIDTH (ENTRY_BITS)
  ) u_ring_mem (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (head_slot_q),
    .wdata_i (payload_q),
    .re_i    (ring_re),
    .raddr_i (eff_slot_d),
    .rdata_o (ring_rdata)
  );

  bor_cursor_mem #(
    .NUM_READERS (NUM_READERS),
    .WIDTH       (CUR_W)
  ) u_cursor_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (accept),
    .ridx_i  (IW'(reader_id_i)),
    .rdata_o (cur_rdata),
    .we_i    (cur_we),
    .widx_i  (IW'(rid_q)),
    .wdata_i (cur_wdata)
  );

  // Cursor check against the oldest kept entry
  assign rid_ok     = (32'(rid_q) < NUM_READERS);
  assign cur_cnt    = cur_rdata[CUR_W-1:AW];
  assign cur_slot   = cur_rdata[AW-1:0];
  assign head_above = (head_q > COUNT_W'(RING_DEPTH));
  assign oldest     = head_above ? head_sub_q : '0;
  assign empty      = (cur_cnt == head_q);
  assign lagging    = (cur_cnt < oldest);

  // Advance a cursor, slot follows the count modulo the depth
  assign eff_inc      = eff_q + COUNT_W'(1);
  assign eff_slot_inc = ((eff_q == '1) || (eff_slot_q == AW'(RING_DEPTH - 1)))
                      ? '0 : eff_slot_q + AW'(1);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if ((cmd_q == CMD_READ) && rid_ok && !empty) state_d = ST_FETCH;
        else                                          state_d = ST_IDLE;
      end
      ST_FETCH: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs per state
  always_comb begin
    head_d      = head_q;
    head_sub_d  = head_sub_q;
    head_slot_d = head_slot_q;
    pub_d       = pub_q;
    drop_d      = drop_q;
    eff_d       = eff_q;
    eff_slot_d  = eff_slot_q;
    over_d      = over_q;
    res_valid_d = 1'b0;
    status_d    = status_q;
    rdata_d     = rdata_q;
    overrun_d   = overrun_q;
    pubc_d      = pubc_q;
    dropc_d     = dropc_q;
    ring_we     = 1'b0;
    ring_re     = 1'b0;
    cur_we      = 1'b0;
    cur_wdata   = {eff_inc, eff_slot_inc};

    unique case (state_q)
      ST_IDLE: begin
      end
      ST_EXEC: begin
        res_valid_d = 1'b1;
        status_d    = STATUS_OK;
        rdata_d     = '0;
        overrun_d   = 1'b0;
        pubc_d      = '0;
        dropc_d     = '0;
        unique case (cmd_q)
          CMD_PUBLISH: begin
            // Store at head and advance counts
            ring_we     = 1'b1;
            head_d      = head_q + COUNT_W'(1);
            head_sub_d  = head_sub_q + COUNT_W'(1);
            head_slot_d = ((head_q == '1) || (head_slot_q == AW'(RING_DEPTH - 1)))
                        ? '0 : head_slot_q + AW'(1);
            pub_d       = pub_q + COUNT_W'(1);
            if ((head_q >= COUNT_W'(RING_DEPTH)) && (head_q != '1)) begin
              drop_d = head_sub_q + COUNT_W'(1);
            end
          end
          CMD_READ: begin
            eff_d      = lagging ? oldest : cur_cnt;
            eff_slot_d = lagging ? head_slot_q : cur_slot;
            over_d     = lagging;
            if (!rid_ok || empty) begin
              status_d = STATUS_EMPTY;
            end else begin
              // Hold the result until the ring entry arrives
              res_valid_d = 1'b0;
              ring_re     = 1'b1;
            end
          end
          CMD_OPEN: begin
            cur_wdata = {head_q, head_slot_q};
            if (rid_ok) cur_we = 1'b1;
            else        status_d = STATUS_EMPTY;
          end
          CMD_STATS: begin
            pubc_d  = pub_q;
            dropc_d = drop_q;
          end
          default: begin
          end
        endcase
      end
      ST_FETCH: begin
        // Return the entry and write back the advanced cursor
        cur_we      = 1'b1;
        res_valid_d = 1'b1;
        status_d    = STATUS_OK;
        rdata_d     = DATA_W'(ring_rdata);
        overrun_d   = over_q;
        pubc_d      = '0;
        dropc_d     = '0;
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      head_sub_q  <= COUNT_W'(0) - COUNT_W'(RING_DEPTH);
      head_slot_q <= '0;
      pub_q       <= '0;
      drop_q      <= '0;
      res_valid_q <= 1'b0;
      cmd_q       <= CMD_PUBLISH;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      head_sub_q  <= head_sub_d;
      head_slot_q <= head_slot_d;
      pub_q       <= pub_d;
      drop_q      <= drop_d;
      res_valid_q <= res_valid_d;
      if (accept) cmd_q <= cmd_e'(cmd_i);
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rid_q     <= reader_id_i;
      payload_q <= payload_i[ENTRY_BITS-1:0];
    end
    eff_q      <= eff_d;
    eff_slot_q <= eff_slot_d;
    over_q     <= over_d;
    status_q   <= status_d;
    rdata_q    <= rdata_d;
    overrun_q  <= overrun_d;
    pubc_q     <= pubc_d;
    dropc_q    <= dropc_d;
  end

  assign result_valid_o    = res_valid_q;
  assign status_o          = status_q;
  assign read_data_o       = rdata_q;
  assign overrun_o         = overrun_q;
  assign published_count_o = pubc_q;
  assign dropped_count_o   = dropc_q;

endmodule
